// ===== rtl/implicit_list_first_fit_allocator_assert.svh =====
// Assertion macros used by the allocator RTL.
// ASSERT_IMPL checks an overlapping implication, ASSERT_NEXT a
// non-overlapping one. Both sample on clk and are off during rst.
`ifndef IMPLICIT_LIST_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define IMPLICIT_LIST_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator assertion failed");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/ilffa_pkg.sv =====
package ilffa_pkg;

  localparam int HEAP_BYTES_DEF  = 65536;
  localparam int CHUNK_BYTES_DEF = 4096;

  localparam logic [31:0] SIZE_MASK = 32'hFFFF_FFF8;
  localparam logic [31:0] ALLOC_BIT = 32'h0000_0001;
  localparam logic [31:0] MIN_BLOCK = 32'd16;
  // First block payload offset, past padding, prologue header and footer and the block's own header.
  localparam logic [31:0] FIRST_BP  = 32'd16;
  localparam logic [31:0] PROLOGUE_TAG = 32'd9;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // One memory access request, byte addressed.
  typedef struct packed {
    logic        re;
    logic [31:0] raddr;
    logic        we;
    logic [31:0] waddr;
    logic [31:0] wdata;
  } mem_req_t;

endpackage

// ===== rtl/ilffa_ram.sv =====
module ilffa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ilffa_tagport.sv =====
module ilffa_tagport #(
  parameter int HEAP_BYTES  = ilffa_pkg::HEAP_BYTES_DEF,
  parameter int CHUNK_BYTES = ilffa_pkg::CHUNK_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ilffa_pkg::mem_req_t req,
  output logic [31:0]         rdata,
  output logic                busy
);
  import ilffa_pkg::*;

  localparam int WORDS    = HEAP_BYTES / 4;
  localparam int AW       = $clog2(WORDS);
  localparam int CHUNKR   = ((CHUNK_BYTES / 4 + 1) / 2) * 8;
  localparam bit INIT_FIT = (16 + CHUNKR) <= HEAP_BYTES;
  localparam int W_FTR    = (16 + CHUNKR - 8) / 4;
  localparam int W_EPI    = (16 + CHUNKR - 4) / 4;

  logic [AW-1:0] cnt;
  logic [31:0]   init_data;
  logic          rd_ok;
  logic          wr_ok;
  logic          rd_ok_q;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [31:0]   ram_rdata;

  // Initial heap image: prologue, one free chunk when it fits, epilogue.
  always_comb begin
    init_data = '0;
    if (cnt == AW'(1) || cnt == AW'(2)) begin
      init_data = PROLOGUE_TAG;
    end else if (cnt == AW'(3)) begin
      init_data = INIT_FIT ? 32'(CHUNKR) : ALLOC_BIT;
    end else if (INIT_FIT && cnt == AW'(W_FTR)) begin
      init_data = 32'(CHUNKR);
    end else if (INIT_FIT && cnt == AW'(W_EPI)) begin
      init_data = ALLOC_BIT;
    end
  end

  assign rd_ok = req.raddr[31:2] < 30'(WORDS);
  assign wr_ok = req.waddr[31:2] < 30'(WORDS);

  assign ram_we    = busy ? 1'b1 : (req.we && wr_ok);
  assign ram_waddr = busy ? cnt : req.waddr[AW+1:2];
  assign ram_wdata = busy ? init_data : req.wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      cnt     <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      if (busy) begin
        cnt <= cnt + AW'(1);
        if (cnt == AW'(WORDS - 1)) begin
          busy <= 1'b0;
        end
      end
      if (req.re) begin
        rd_ok_q <= rd_ok;
      end
    end
  end

  // Reads outside the heap return zero.
  assign rdata = rd_ok_q ? ram_rdata : '0;

  ilffa_ram #(
    .WIDTH(32),
    .DEPTH(WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (req.re),
    .raddr(req.raddr[AW+1:2]),
    .rdata(ram_rdata)
  );

endmodule

// ===== rtl/implicit_list_first_fit_allocator.sv =====
// Heap allocator over a word memory with boundary tags (first fit).
// Input channel s_*: one transaction is one command. s_tuser carries the
// opcode (allocate or free), s_tdata the request size and the block to free.
// Output channel m_*: exactly one transaction per command, carrying the
// payload address in m_tdata and the failure flag in m_tuser.
// Commands are processed one at a time. An allocate's first-fit walk
// reads one tag per block visited, one per memory access, so it takes
// longer as the heap fragments; the allocate then marks the chosen block,
// splitting off a free remainder when it is large enough. When the walk
// misses, the heap first grows by a new free block merged with its
// neighbours, or the allocate fails if there is no room. A free marks the
// block free and merges it likewise. After reset the block sweeps the
// whole memory, one word per cycle, writing the initial prologue, free
// chunk and epilogue; s_tready stays low until the sweep ends.
// The result sits in an output register; if the receiver stalls, the
// finished command waits there, and the next command can already be taken
// but cannot deliver until the register is emptied.
module implicit_list_first_fit_allocator #(
  parameter int HEAP_BYTES  = ilffa_pkg::HEAP_BYTES_DEF,
  parameter int CHUNK_BYTES = ilffa_pkg::CHUNK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [16:0] request_bytes, [32:17] block_address
  input  logic [0:0]  s_tuser,   // [0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] payload_address
  output logic [0:0]  m_tuser    // [0] failed
);
  import ilffa_pkg::*;
  `include "implicit_list_first_fit_allocator_assert.svh"

  localparam int CHUNKR   = ((CHUNK_BYTES / 4 + 1) / 2) * 8;
  localparam bit INIT_FIT = (16 + CHUNKR) <= HEAP_BYTES;
  localparam logic [31:0] INIT_BRK = INIT_FIT ? 32'(16 + CHUNKR) : 32'd16;

  typedef enum logic [4:0] {
    ST_IDLE, ST_WALK_RD, ST_WALK_CHK, ST_GROW, ST_G_EPI,
    ST_M_R1, ST_M_C1, ST_M_R2, ST_M_C2, ST_M_R3, ST_M_C3, ST_M_R4, ST_M_C4,
    ST_M_ADDN, ST_M_END, ST_CARVE_RD, ST_CARVE_CHK, ST_CARVE2,
    ST_FREE_RD, ST_FREE_CHK, ST_TAG_W1, ST_TAG_W2, ST_RESULT
  } state_t;

  state_t      state;
  state_t      ret;
  logic        op;
  logic [31:0] bp;
  logic [32:0] wp;
  logic [17:0] need;
  logic [31:0] size;
  logic [31:0] nxt;
  logic [31:0] prev;
  logic [31:0] psize;
  logic [31:0] nsize;
  logic        pu;
  logic [31:0] tp;
  logic [31:0] ts;
  logic        ta;
  logic [31:0] brk;
  logic [15:0] res_addr;
  logic        res_fail;
  logic        out_load;

  mem_req_t    mreq;
  logic [31:0] rdata;
  logic        init_busy;

  logic [16:0] req_bytes;
  logic [17:0] req_sum;
  logic [17:0] need_calc;
  logic [31:0] rd_size;
  logic [31:0] need32;
  logic [31:0] grow_bytes;
  logic [32:0] grow_end;
  logic [31:0] carve_rem;

  assign req_bytes = s_tdata[16:0];
  assign req_sum   = {1'b0, req_bytes} + 18'd15;
  assign need_calc = (req_bytes <= 17'd8) ? 18'd16 : {req_sum[17:3], 3'b000};
  assign rd_size   = rdata & SIZE_MASK;
  assign need32    = {14'd0, need};
  assign grow_bytes = (need32 > 32'(CHUNKR)) ? need32 : 32'(CHUNKR);
  assign grow_end  = {1'b0, brk} + {1'b0, grow_bytes};
  assign carve_rem = rd_size - need32;

  assign s_tready = (state == ST_IDLE) && !init_busy;

  // The output register takes a new result when it is empty or being drained.
  assign out_load = (state == ST_RESULT) && (!m_tvalid || m_tready);

  // Memory accesses, at most one per state, in the order the algorithm issues them.
  always_comb begin
    mreq = '0;
    case (state)
      ST_WALK_RD: begin
        mreq.re    = 1'b1;
        mreq.raddr = wp[31:0] - 32'd4;
      end
      ST_M_R1, ST_CARVE_RD, ST_FREE_RD: begin
        mreq.re    = 1'b1;
        mreq.raddr = bp - 32'd4;
      end
      ST_M_R2: begin
        mreq.re    = 1'b1;
        mreq.raddr = bp - 32'd8;
      end
      ST_M_R3: begin
        mreq.re    = 1'b1;
        mreq.raddr = prev - 32'd4;
      end
      ST_M_R4: begin
        mreq.re    = 1'b1;
        mreq.raddr = nxt - 32'd4;
      end
      ST_TAG_W1: begin
        mreq.we    = 1'b1;
        mreq.waddr = tp - 32'd4;
        mreq.wdata = ts | {31'd0, ta};
      end
      ST_TAG_W2: begin
        mreq.we    = 1'b1;
        mreq.waddr = tp + ts - 32'd8;
        mreq.wdata = ts | {31'd0, ta};
      end
      ST_G_EPI: begin
        mreq.we    = 1'b1;
        mreq.waddr = tp + ts - 32'd4;
        mreq.wdata = ALLOC_BIT;
      end
      default: begin
        mreq = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ret      <= ST_IDLE;
      brk      <= INIT_BRK;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            op   <= s_tuser[0];
            need <= need_calc;
            bp   <= {16'd0, s_tdata[32:17]};
            wp   <= {1'b0, FIRST_BP};
            state <= (s_tuser[0] == OP_FREE) ? ST_FREE_RD : ST_WALK_RD;
          end
        end
        // First-fit walk: one tag read per block.
        ST_WALK_RD: begin
          if ((wp - 33'd4) < {1'b0, brk}) begin
            state <= ST_WALK_CHK;
          end else begin
            state <= ST_GROW;
          end
        end
        ST_WALK_CHK: begin
          if (rd_size == '0) begin
            state <= ST_GROW;
          end else if (!rdata[0] && rd_size >= need32) begin
            bp    <= wp[31:0];
            state <= ST_CARVE_RD;
          end else begin
            wp    <= wp + {1'b0, rd_size};
            state <= ST_WALK_RD;
          end
        end
        // Miss: extend the break by a new free block and epilogue, or fail when the heap has no room.
        ST_GROW: begin
          if (grow_end <= 33'(HEAP_BYTES)) begin
            tp    <= brk;
            ts    <= grow_bytes;
            ta    <= 1'b0;
            bp    <= brk;
            ret   <= ST_G_EPI;
            state <= ST_TAG_W1;
          end else begin
            res_addr <= '0;
            res_fail <= 1'b1;
            state    <= ST_RESULT;
          end
        end
        ST_G_EPI: begin
          brk   <= brk + ts;
          state <= ST_M_R1;
        end
        // Coalescing with both neighbors.
        ST_M_R1: state <= ST_M_C1;
        ST_M_C1: begin
          size  <= rd_size;
          nxt   <= bp + rd_size;
          state <= ST_M_R2;
        end
        ST_M_R2: state <= ST_M_C2;
        ST_M_C2: begin
          prev  <= bp - rd_size;
          state <= ST_M_R3;
        end
        ST_M_R3: state <= ST_M_C3;
        ST_M_C3: begin
          psize <= rd_size;
          pu    <= rdata[0];
          state <= ST_M_R4;
        end
        ST_M_R4: state <= ST_M_C4;
        ST_M_C4: begin
          nsize <= rd_size;
          ta    <= 1'b0;
          ret   <= ST_M_END;
          if (pu && rdata[0]) begin
            state <= ST_M_END;
          end else if (pu) begin
            tp    <= bp;
            ts    <= size + rd_size;
            state <= ST_TAG_W1;
          end else begin
            tp    <= prev;
            bp    <= prev;
            ts    <= size + psize;
            state <= rdata[0] ? ST_TAG_W1 : ST_M_ADDN;
          end
        end
        ST_M_ADDN: begin
          ts    <= ts + nsize;
          state <= ST_TAG_W1;
        end
        ST_M_END: begin
          if (op == OP_FREE) begin
            res_addr <= '0;
            res_fail <= 1'b0;
            state    <= ST_RESULT;
          end else begin
            state <= ST_CARVE_RD;
          end
        end
        // Carve the request out of the chosen block, splitting if the
        // remainder is large enough to be a block of its own.
        ST_CARVE_RD: state <= ST_CARVE_CHK;
        ST_CARVE_CHK: begin
          res_addr <= bp[15:0];
          res_fail <= 1'b0;
          tp       <= bp;
          ta       <= 1'b1;
          size     <= carve_rem;
          if (rd_size < need32 || carve_rem < MIN_BLOCK) begin
            ts  <= rd_size;
            ret <= ST_RESULT;
          end else begin
            ts  <= need32;
            ret <= ST_CARVE2;
          end
          state <= ST_TAG_W1;
        end
        ST_CARVE2: begin
          tp    <= bp + need32;
          ts    <= size;
          ta    <= 1'b0;
          ret   <= ST_RESULT;
          state <= ST_TAG_W1;
        end
        // Free: mark the block free, then coalesce.
        ST_FREE_RD: state <= ST_FREE_CHK;
        ST_FREE_CHK: begin
          tp    <= bp;
          ts    <= rd_size;
          ta    <= 1'b0;
          ret   <= ST_M_R1;
          state <= ST_TAG_W1;
        end
        ST_TAG_W1: state <= ST_TAG_W2;
        ST_TAG_W2: state <= ret;
        ST_RESULT: begin
          if (out_load) begin
            m_tdata    <= res_addr;
            m_tuser[0] <= res_fail;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  ilffa_tagport #(
    .HEAP_BYTES (HEAP_BYTES),
    .CHUNK_BYTES(CHUNK_BYTES)
  ) u_tagport (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .rdata(rdata),
    .busy (init_busy)
  );

  `ASSERT_IMPL(a_no_rw_overlap, mreq.we, !mreq.re)
  `ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)
  `ASSERT_IMPL(a_fail_zero_addr, m_tvalid && m_tuser[0], m_tdata == 16'd0)
  `ASSERT_IMPL(a_break_in_heap, state != ST_IDLE, {1'b0, brk} <= 33'(HEAP_BYTES))

endmodule

// ===== bench/alloc_checker.sv =====
module alloc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // [16:0] request_bytes, [32:17] block_address
  input  logic [0:0]  s_tuser,   // [0] opcode
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // [15:0] payload_address
  input  logic [0:0]  m_tuser,   // [0] failed
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ilffa_pkg::*;

  localparam int WORDS = HEAP_BYTES_DEF / 4;

  typedef struct packed {
    logic [15:0] payload_address;
    logic        failed;
  } alloc_result_t;

  logic [31:0]   heap_mem [WORDS];
  logic [31:0]   heap_top;
  alloc_result_t expected_results[$];

  function automatic logic [31:0] peek(input logic [31:0] a);
    logic [31:0] idx;
    idx = a >> 2;
    if (idx < WORDS) return heap_mem[idx];
    return 32'd0;
  endfunction

  function automatic void poke(input logic [31:0] a, input logic [31:0] v);
    logic [31:0] idx;
    idx = a >> 2;
    if (idx < WORDS) heap_mem[idx] = v;
  endfunction

  function automatic logic [31:0] tag_size(input logic [31:0] bp);
    return peek(bp - 32'd4) & SIZE_MASK;
  endfunction

  function automatic logic tag_used(input logic [31:0] bp);
    logic [31:0] t;
    t = peek(bp - 32'd4);
    return t[0];
  endfunction

  function automatic void write_tags(input logic [31:0] bp, input logic [31:0] size,
                                     input logic used);
    logic [31:0] t;
    t = size | {31'd0, used};
    poke(bp - 32'd4, t);
    poke(bp + size - 32'd8, t);
  endfunction

  function automatic logic [31:0] coalesce(input logic [31:0] bp);
    logic [31:0] size, next_bp, prev_bp;
    logic        prev_used, next_used;
    size      = tag_size(bp);
    next_bp   = bp + size;
    prev_bp   = bp - (peek(bp - 32'd8) & SIZE_MASK);
    prev_used = tag_used(prev_bp);
    next_used = tag_used(next_bp);
    if (prev_used && next_used) return bp;
    if (prev_used) begin
      size += tag_size(next_bp);
      write_tags(bp, size, 1'b0);
      return bp;
    end
    size += tag_size(prev_bp);
    if (!next_used) size += tag_size(next_bp);
    write_tags(prev_bp, size, 1'b0);
    return prev_bp;
  endfunction

  // Marks the block used, splitting off a free tail when it is big enough.
  function automatic void split_block(input logic [31:0] bp, input logic [31:0] need);
    logic [31:0] size;
    size = tag_size(bp);
    if (size < need || size - need < MIN_BLOCK) begin
      write_tags(bp, size, 1'b1);
    end else begin
      write_tags(bp, need, 1'b1);
      write_tags(bp + need, size - need, 1'b0);
    end
  endfunction

  function automatic logic [31:0] scan_first_fit(input logic [31:0] need);
    longint unsigned bp;
    logic [31:0]     t, size;
    bp = FIRST_BP;
    while (bp - 4 < longint'(heap_top)) begin
      t    = peek(bp[31:0] - 32'd4);
      size = t & SIZE_MASK;
      if (size == 0) return 32'd0;
      if (!t[0] && size >= need) return bp[31:0];
      bp += size;
    end
    return 32'd0;
  endfunction

  function automatic logic [31:0] raise_break(input logic [31:0] bytes);
    logic [31:0] bp;
    bp = heap_top;
    if (longint'(bp) + longint'(bytes) > HEAP_BYTES_DEF) return 32'd0;
    write_tags(bp, bytes, 1'b0);
    poke(bp + bytes - 32'd4, ALLOC_BIT);
    heap_top = bp + bytes;
    return coalesce(bp);
  endfunction

  function automatic void init_heap();
    logic [31:0] words;
    for (int i = 0; i < WORDS; i++) heap_mem[i] = 32'd0;
    poke(32'd4, PROLOGUE_TAG);
    poke(32'd8, PROLOGUE_TAG);
    poke(32'd12, ALLOC_BIT);
    heap_top = 32'd16;
    words = CHUNK_BYTES_DEF / 4;
    if (words[0]) words++;
    void'(raise_break(words * 4));
  endfunction

  function automatic alloc_result_t predict_command(input logic op, input logic [16:0] req,
                                                    input logic [15:0] addr);
    alloc_result_t r;
    logic [31:0]   need, bp, words;
    r = '0;
    if (op == OP_FREE) begin
      write_tags({16'd0, addr}, tag_size({16'd0, addr}), 1'b0);
      void'(coalesce({16'd0, addr}));
      return r;
    end
    need = (req <= 17'd8) ? MIN_BLOCK : 32'd8 * ((32'(req) + 32'd15) / 32'd8);
    bp = scan_first_fit(need);
    if (bp == 0) begin
      words = need / 4;
      if (CHUNK_BYTES_DEF / 4 > words) words = CHUNK_BYTES_DEF / 4;
      if (words[0]) words++;
      bp = raise_break(words * 4);
      if (bp == 0) begin
        r.failed = 1'b1;
        return r;
      end
    end
    split_block(bp, need);
    r.payload_address = bp[15:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  initial begin
    errors  = 0;
    pending = 0;
    init_heap();
  end

  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result addr=%0d failed=%0b",
                                    m_tdata, m_tuser[0]));
        end else begin
          exp_r = expected_results.pop_front();
          if (m_tdata !== exp_r.payload_address)
            report_mismatch($sformatf("payload_address got %0d want %0d",
                                      m_tdata, exp_r.payload_address));
          if (m_tuser[0] !== exp_r.failed)
            report_mismatch($sformatf("failed got %0b want %0b",
                                      m_tuser[0], exp_r.failed));
        end
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(predict_command(s_tuser[0], s_tdata[16:0],
                                                   s_tdata[32:17]));
      pending <= expected_results.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ilffa_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // [16:0] request_bytes, [32:17] block_address
  logic [0:0]  s_tuser = '0;   // [0] opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [15:0] payload_address
  logic [0:0]  m_tuser;        // [0] failed

  int errors, pending;

  // Percent chance per cycle that the sender holds off or the receiver stalls.
  int send_idle  = 0;
  int recv_stall = 0;

  // Payload addresses handed out and not yet freed; frees are drawn from here.
  logic [15:0] live_blocks[$];
  bit          last_failed;
  int          n_alloc_ok, n_alloc_fail, n_free;

  always #5 clk = ~clk;

  implicit_list_first_fit_allocator DUT (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  alloc_checker checker_i (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .errors, .pending
  );

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else     m_tready <= ($urandom_range(99) >= recv_stall);
  end

  // Watch the result channel to learn which blocks are live. A free returns
  // address zero with no failure, so it is never taken for an allocation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (m_tuser[0]) begin
        n_alloc_fail++;
        last_failed = 1'b1;
      end else if (m_tdata != 16'd0) begin
        n_alloc_ok++;
        last_failed = 1'b0;
        live_blocks.push_back(m_tdata);
      end else begin
        n_free++;
      end
    end
  end

  // Offers one command and holds it until the transaction completes. The
  // valid stays high between back-to-back commands.
  task automatic send_command(input logic op, input logic [16:0] req,
                              input logic [15:0] addr);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'd0, addr, req};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic free_live(input int idx);
    logic [15:0] a;
    a = live_blocks[idx];
    live_blocks.delete(idx);
    send_command(OP_FREE, 17'd0, a);
  endtask

  // One random command: mostly well-formed allocate/free traffic, leaning
  // toward frees once the heap has run out, with a rare stray free.
  task automatic random_command();
    int          pick, r;
    logic [16:0] req;
    pick = $urandom_range(99);
    if (pick == 0) begin
      send_command(OP_FREE, 17'd0, 16'($urandom_range(65535)));
    end else if (live_blocks.size() > 0 && (pick < 40 || (last_failed && pick < 85))) begin
      free_live($urandom_range(live_blocks.size() - 1));
    end else begin
      r = $urandom_range(99);
      if (r < 70)      req = 17'($urandom_range(200));
      else if (r < 90) req = 17'($urandom_range(4096));
      else if (r < 98) req = 17'($urandom_range(20000));
      else             req = 17'($urandom_range(131071));
      send_command(OP_ALLOC, req, 16'd0);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Zero-byte, small and just-over-small requests, then frees that cover
    // the both-used, both-free and only-next-free neighbour cases of the merge.
    send_command(OP_ALLOC, 17'd0, 16'd0);
    send_command(OP_ALLOC, 17'd1, 16'd0);
    send_command(OP_ALLOC, 17'd8, 16'd0);
    send_command(OP_ALLOC, 17'd9, 16'd0);
    send_command(OP_ALLOC, 17'd24, 16'd0);
    wait_drained();
    if (live_blocks.size() == 5) begin
      send_command(OP_FREE, 17'd0, live_blocks[1]);  // both neighbours used
      send_command(OP_FREE, 17'd0, live_blocks[3]);  // both neighbours used
      send_command(OP_FREE, 17'd0, live_blocks[2]);  // both neighbours free
      send_command(OP_FREE, 17'd0, live_blocks[0]);  // only the next one free
      send_command(OP_FREE, 17'd0, live_blocks[4]);  // previous free too
    end
    live_blocks.delete();
    // Exact chunk fits, forced heap growths, and requests too big to serve.
    send_command(OP_ALLOC, 17'd4080, 16'd0);
    send_command(OP_ALLOC, 17'd4096, 16'd0);
    send_command(OP_ALLOC, 17'd20000, 16'd0);
    send_command(OP_ALLOC, 17'd60000, 16'd0);
    send_command(OP_ALLOC, 17'd65536, 16'd0);
    send_command(OP_ALLOC, 17'd131071, 16'd0);
    // A stray free of address zero touches only the space outside the heap.
    send_command(OP_FREE, 17'd0, 16'd0);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 85; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 85; end
        default: begin send_idle = 8; recv_stall = 8; end
      endcase
      repeat (450) random_command();
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    recv_stall = 0;
    repeat (200) @(posedge clk);

    $display("Covered %0d successful allocations, %0d failed allocations, %0d frees,",
             n_alloc_ok, n_alloc_fail, n_free);
    $display("across four sender/receiver pacing phases.");
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Generous cap: worst walks over a fragmented heap, stalls and the sweep.
  initial begin
    #2s;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ilffa_pkg.sv
rtl/ilffa_ram.sv
rtl/ilffa_tagport.sv
rtl/implicit_list_first_fit_allocator.sv
bench/alloc_checker.sv
bench/tb.sv
